@@ rtl/dbr_pkg.sv @@
// ---------------------------------------------------------------------------
// dbr_pkg
// Shared types and register codes for the diffuse boundary reflection block.
// ---------------------------------------------------------------------------
package dbr_pkg;

  localparam int LIMIT_W   = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LIMIT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LIMIT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LIMIT_Z = 2'd2;

  localparam logic [LIMIT_W-1:0] BOX_LIMIT_RST = 31'd1048576;

  // per-axis control travelling with an item
  typedef struct packed {
    logic hit;
    logic below;
    logic degen;
  } dbr_ctl_t;

endpackage

@@ rtl/dbr_axis.sv @@
// ---------------------------------------------------------------------------
// dbr_axis
// One axis of the reflection: square, three digit-serial square roots, two
// scaled tangentials with a one-bit-per-stage divider, then the new normal.
// ---------------------------------------------------------------------------
module dbr_axis #(
  parameter int DIR_FRAC_BITS = 14,
  parameter int RAND_BITS     = 16,
  parameter int XW            = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   vld_i,
  input  dbr_pkg::dbr_ctl_t                      ctl_i,
  input  logic [((DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16)-1:0] a_i,
  input  logic [((DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16)-1:0] b_i,
  input  logic [((DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16)-1:0] c_i,
  input  logic [RAND_BITS-1:0]                   rand_i,
  input  logic [XW-1:0]                          side_i,
  output logic                                   vld_o,
  output dbr_pkg::dbr_ctl_t                      ctl_o,
  output logic [((DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16)-1:0] a_o,
  output logic [((DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16)-1:0] b_o,
  output logic [((DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16)-1:0] c_o,
  output logic [XW-1:0]                          side_o
);

  localparam int F    = DIR_FRAC_BITS;
  localparam int DW   = (F + 2 > 16) ? F + 2 : 16;
  localparam int NR   = F + 1;
  localparam int RADW = 2 * NR;
  localparam int REMW = NR + 2;
  localparam int SQW  = 2 * DW;
  localparam int PW   = DW + NR;
  localparam int NW   = PW + 1;

  localparam int ST_P   = 3 + NR;
  localparam int ST_A   = ST_P + 1;
  localparam int ST_C   = ST_P + 2;
  localparam int ST_D0  = ST_P + 3;
  localparam int ST_FIN = ST_D0 + NR;
  localparam int NSTG   = ST_FIN + 1;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [NR-1:0]   root;
  } sqs_t;

  typedef struct packed {
    dbr_pkg::dbr_ctl_t ctl;
    logic [DW-1:0]     a;
    logic [DW-1:0]     b;
    logic [DW-1:0]     c;
    logic [XW-1:0]     side;
    logic [DW-1:0]     aa;
    logic [RADW-1:0]   rq;
    logic [SQW-1:0]    sq;
    sqs_t              s_old;
    sqs_t              s_cos;
    sqs_t              s_sin;
    logic [PW-1:0]     pb;
    logic [PW-1:0]     pc;
    logic [NW-1:0]     nb;
    logic [NW-1:0]     nc;
    logic [NW-1:0]     lim;
    logic              satb;
    logic              satc;
    logic [NR-1:0]     qb;
    logic [NR-1:0]     qc;
  } wk_t;

  function automatic sqs_t sqrt_step(sqs_t s);
    sqs_t            o;
    logic [REMW-1:0] rem2;
    logic [REMW-1:0] trial;
    rem2  = {s.rem[REMW-3:0], s.rad[RADW-1 -: 2]};
    trial = {s.root, 2'b01};
    o.rad = {s.rad[RADW-3:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[NR-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[NR-2:0], 1'b0};
    end
    return o;
  endfunction

  wk_t  wk_q  [NSTG];
  logic vld_q [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    wk_t  nxt;
    logic vld_d;

    if (i == 0) begin : g_entry
      assign vld_d = vld_i;
      always_comb begin
        nxt      = '0;
        nxt.ctl  = ctl_i;
        nxt.a    = a_i;
        nxt.b    = b_i;
        nxt.c    = c_i;
        nxt.side = side_i;
        nxt.aa   = a_i[DW-1] ? DW'(DW'(0) - a_i) : a_i;
        if (2 * F >= RAND_BITS) begin
          nxt.rq = RADW'(rand_i) << (2 * F - RAND_BITS);
        end else begin
          nxt.rq = RADW'(rand_i >> (RAND_BITS - 2 * F));
        end
      end
    end else begin : g_work
      assign vld_d = vld_q[i-1];

      if (i == 1) begin : g_sq
        always_comb begin
          nxt    = wk_q[i-1];
          nxt.sq = SQW'(wk_q[i-1].aa) * SQW'(wk_q[i-1].aa);
        end
      end else if (i == 2) begin : g_rad
        logic [SQW-1:0]  full_s;
        logic [RADW-1:0] full_r;
        assign full_s = SQW'(1) << (2 * F);
        assign full_r = RADW'(1) << (2 * F);
        always_comb begin
          nxt = wk_q[i-1];
          nxt.s_old = '0;
          nxt.s_cos = '0;
          nxt.s_sin = '0;
          if (wk_q[i-1].sq < full_s) begin
            nxt.s_old.rad = RADW'(full_s - wk_q[i-1].sq);
          end
          nxt.s_cos.rad = wk_q[i-1].rq;
          nxt.s_sin.rad = full_r - wk_q[i-1].rq;
        end
      end else if (i < ST_P) begin : g_sqrt
        always_comb begin
          nxt       = wk_q[i-1];
          nxt.s_old = sqrt_step(wk_q[i-1].s_old);
          nxt.s_cos = sqrt_step(wk_q[i-1].s_cos);
          nxt.s_sin = sqrt_step(wk_q[i-1].s_sin);
        end
      end else if (i == ST_P) begin : g_prod
        logic [DW-1:0] bm;
        logic [DW-1:0] cm;
        assign bm = wk_q[i-1].b[DW-1] ? DW'(DW'(0) - wk_q[i-1].b) : wk_q[i-1].b;
        assign cm = wk_q[i-1].c[DW-1] ? DW'(DW'(0) - wk_q[i-1].c) : wk_q[i-1].c;
        always_comb begin
          nxt    = wk_q[i-1];
          nxt.pb = PW'(bm) * PW'(wk_q[i-1].s_sin.root);
          nxt.pc = PW'(cm) * PW'(wk_q[i-1].s_sin.root);
        end
      end else if (i == ST_A) begin : g_add
        logic [NW-1:0] den;
        assign den = NW'(wk_q[i-1].s_old.root);
        always_comb begin
          nxt     = wk_q[i-1];
          nxt.nb  = NW'(wk_q[i-1].pb) + (den >> 1);
          nxt.nc  = NW'(wk_q[i-1].pc) + (den >> 1);
          nxt.lim = (den << F) + den;
        end
      end else if (i == ST_C) begin : g_cmp
        always_comb begin
          nxt      = wk_q[i-1];
          nxt.satb = wk_q[i-1].nb >= wk_q[i-1].lim;
          nxt.satc = wk_q[i-1].nc >= wk_q[i-1].lim;
        end
      end else if (i < ST_FIN) begin : g_div
        localparam int K = F - (i - ST_D0);
        logic [NW-1:0] dk;
        assign dk = NW'(wk_q[i-1].s_old.root) << K;
        always_comb begin
          nxt = wk_q[i-1];
          if (wk_q[i-1].nb >= dk) begin
            nxt.nb = wk_q[i-1].nb - dk;
            nxt.qb = {wk_q[i-1].qb[NR-2:0], 1'b1};
          end else begin
            nxt.qb = {wk_q[i-1].qb[NR-2:0], 1'b0};
          end
          if (wk_q[i-1].nc >= dk) begin
            nxt.nc = wk_q[i-1].nc - dk;
            nxt.qc = {wk_q[i-1].qc[NR-2:0], 1'b1};
          end else begin
            nxt.qc = {wk_q[i-1].qc[NR-2:0], 1'b0};
          end
        end
      end else begin : g_fin
        logic [DW-1:0] one;
        logic [DW-1:0] mb;
        logic [DW-1:0] mc;
        logic [DW-1:0] cn;
        logic          zero;
        assign one  = DW'(1) << F;
        assign mb   = wk_q[i-1].satb ? one : DW'(wk_q[i-1].qb);
        assign mc   = wk_q[i-1].satc ? one : DW'(wk_q[i-1].qc);
        assign cn   = DW'(wk_q[i-1].s_cos.root);
        assign zero = (wk_q[i-1].s_old.root == '0);
        always_comb begin
          nxt = wk_q[i-1];
          if (wk_q[i-1].ctl.hit) begin
            nxt.a = wk_q[i-1].ctl.below ? cn : DW'(DW'(0) - cn);
            if (zero) begin
              nxt.b         = '0;
              nxt.c         = '0;
              nxt.ctl.degen = 1'b1;
            end else begin
              nxt.b = wk_q[i-1].b[DW-1] ? DW'(DW'(0) - mb) : mb;
              nxt.c = wk_q[i-1].c[DW-1] ? DW'(DW'(0) - mc) : mc;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wk_q[i] <= nxt;
      end
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign ctl_o  = wk_q[NSTG-1].ctl;
  assign a_o    = wk_q[NSTG-1].a;
  assign b_o    = wk_q[NSTG-1].b;
  assign c_o    = wk_q[NSTG-1].c;
  assign side_o = wk_q[NSTG-1].side;

endmodule

@@ rtl/diffuse_boundary_reflect.sv @@
// ---------------------------------------------------------------------------
// diffuse_boundary_reflect
// Diffuse wall reflection of a particle direction, axes taken as y, x, z.
// ---------------------------------------------------------------------------
// Port group    Dir  Handshake                Content
// in_*          in   in_valid_i / in_ready_o  position, direction, random
// out_*         out  out_valid_o / out_ready_i new direction, hit mask, flag
// cfg_*         in   cfg_we_i                 box limits x, y, z
//
// One item per cycle. The pipeline depth is set by the per-axis square-root
// and divider stages, with the three axes in series.
// The whole pipeline advances together; it holds while a result is not taken.
// Reset clears the valid bits and loads the default box limits.
// ---------------------------------------------------------------------------
module diffuse_boundary_reflect #(
  parameter int DIR_FRAC_BITS = 14,
  parameter int RAND_BITS     = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [31:0]                      pos_x_i,
  input  logic [31:0]                      pos_y_i,
  input  logic [31:0]                      pos_z_i,
  input  logic [15:0]                      dir_in_x_i,
  input  logic [15:0]                      dir_in_y_i,
  input  logic [15:0]                      dir_in_z_i,
  input  logic [15:0]                      rand_for_y_i,
  input  logic [15:0]                      rand_for_x_i,
  input  logic [15:0]                      rand_for_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [15:0]                      dir_out_x_o,
  output logic [15:0]                      dir_out_y_o,
  output logic [15:0]                      dir_out_z_o,
  output logic [2:0]                       hit_mask_o,
  output logic                             degenerate_o,
  input  logic                             cfg_we_i,
  input  logic [dbr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dbr_pkg::LIMIT_W-1:0]      cfg_data_i
);

  localparam int DW = (DIR_FRAC_BITS + 2 > 16) ? DIR_FRAC_BITS + 2 : 16;

  typedef struct packed {
    logic [RAND_BITS-1:0] rand_x;
    logic [RAND_BITS-1:0] rand_z;
    logic                 hit_x;
    logic                 below_x;
    logic                 hit_z;
    logic                 below_z;
    logic [2:0]           mask;
  } side_t;

  localparam int XW = $bits(side_t);

  logic [dbr_pkg::LIMIT_W-1:0] box_limit_x_q;
  logic [dbr_pkg::LIMIT_W-1:0] box_limit_y_q;
  logic [dbr_pkg::LIMIT_W-1:0] box_limit_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_limit_x_q <= dbr_pkg::BOX_LIMIT_RST;
      box_limit_y_q <= dbr_pkg::BOX_LIMIT_RST;
      box_limit_z_q <= dbr_pkg::BOX_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbr_pkg::REG_BOX_LIMIT_X: box_limit_x_q <= cfg_data_i;
        dbr_pkg::REG_BOX_LIMIT_Y: box_limit_y_q <= cfg_data_i;
        dbr_pkg::REG_BOX_LIMIT_Z: box_limit_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic hit_x, hit_y, hit_z;
  logic below_x, below_y, below_z;

  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  assign below_x = pos_x_i[31];
  assign below_y = pos_y_i[31];
  assign below_z = pos_z_i[31];
  assign hit_x   = below_x | ($signed(pos_x_i) > $signed({1'b0, box_limit_x_q}));
  assign hit_y   = below_y | ($signed(pos_y_i) > $signed({1'b0, box_limit_y_q}));
  assign hit_z   = below_z | ($signed(pos_z_i) > $signed({1'b0, box_limit_z_q}));

  side_t             side_in;
  dbr_pkg::dbr_ctl_t ctl_y_in;

  always_comb begin
    side_in.rand_x  = RAND_BITS'(rand_for_x_i);
    side_in.rand_z  = RAND_BITS'(rand_for_z_i);
    side_in.hit_x   = hit_x;
    side_in.below_x = below_x;
    side_in.hit_z   = hit_z;
    side_in.below_z = below_z;
    side_in.mask    = {hit_z, hit_y, hit_x};
    ctl_y_in.hit    = hit_y;
    ctl_y_in.below  = below_y;
    ctl_y_in.degen  = 1'b0;
  end

  // axis y
  logic              vld_y;
  dbr_pkg::dbr_ctl_t ctl_y;
  logic [DW-1:0]     ay, by, cy;
  logic [XW-1:0]     sy_raw;
  side_t             sy;

  dbr_axis #(
    .DIR_FRAC_BITS (DIR_FRAC_BITS),
    .RAND_BITS     (RAND_BITS),
    .XW            (XW)
  ) u_ax_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .ctl_i  (ctl_y_in),
    .a_i    (DW'($signed(dir_in_y_i))),
    .b_i    (DW'($signed(dir_in_x_i))),
    .c_i    (DW'($signed(dir_in_z_i))),
    .rand_i (RAND_BITS'(rand_for_y_i)),
    .side_i (side_in),
    .vld_o  (vld_y),
    .ctl_o  (ctl_y),
    .a_o    (ay),
    .b_o    (by),
    .c_o    (cy),
    .side_o (sy_raw)
  );

  assign sy = side_t'(sy_raw);

  // axis x
  dbr_pkg::dbr_ctl_t ctl_x_in;
  logic              vld_x;
  dbr_pkg::dbr_ctl_t ctl_x;
  logic [DW-1:0]     ax, bx, cx;
  logic [XW-1:0]     sx_raw;
  side_t             sx;

  assign ctl_x_in = '{hit: sy.hit_x, below: sy.below_x, degen: ctl_y.degen};

  dbr_axis #(
    .DIR_FRAC_BITS (DIR_FRAC_BITS),
    .RAND_BITS     (RAND_BITS),
    .XW            (XW)
  ) u_ax_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_y),
    .ctl_i  (ctl_x_in),
    .a_i    (by),
    .b_i    (ay),
    .c_i    (cy),
    .rand_i (sy.rand_x),
    .side_i (sy_raw),
    .vld_o  (vld_x),
    .ctl_o  (ctl_x),
    .a_o    (ax),
    .b_o    (bx),
    .c_o    (cx),
    .side_o (sx_raw)
  );

  assign sx = side_t'(sx_raw);

  // axis z
  dbr_pkg::dbr_ctl_t ctl_z_in;
  dbr_pkg::dbr_ctl_t ctl_z;
  logic [DW-1:0]     az, bz, cz;
  logic [XW-1:0]     sz_raw;
  side_t             sz;

  assign ctl_z_in = '{hit: sx.hit_z, below: sx.below_z, degen: ctl_x.degen};

  dbr_axis #(
    .DIR_FRAC_BITS (DIR_FRAC_BITS),
    .RAND_BITS     (RAND_BITS),
    .XW            (XW)
  ) u_ax_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_x),
    .ctl_i  (ctl_z_in),
    .a_i    (cx),
    .b_i    (ax),
    .c_i    (bx),
    .rand_i (sx.rand_z),
    .side_i (sx_raw),
    .vld_o  (out_valid_o),
    .ctl_o  (ctl_z),
    .a_o    (az),
    .b_o    (bz),
    .c_o    (cz),
    .side_o (sz_raw)
  );

  assign sz = side_t'(sz_raw);

  assign dir_out_x_o  = bz[15:0];
  assign dir_out_y_o  = cz[15:0];
  assign dir_out_z_o  = az[15:0];
  assign hit_mask_o   = sz.mask;
  assign degenerate_o = ctl_z.degen;

endmodule

@@ sim/tb_diffuse_boundary_reflect.sv @@
// ---------------------------------------------------------------------------
// tb_diffuse_boundary_reflect
// Self-checking bench for the diffuse wall reflection pipeline. A short table
// of directed items is followed by random items over several box limit
// settings. Every accepted result is checked field by field against an
// in-bench bit-accurate model of the y, x, z reflection. Both handshake sides
// idle at random, and the result side holds off once long enough to fill
// the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_diffuse_boundary_reflect;

  localparam int DFB = 14;
  localparam int RB  = 16;
  localparam int N_RAND_PER_PHASE = 170;
  localparam int DRAIN_CYCLES = 3 * (2 * DFB + 9) + 40;
  localparam logic [dbr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [dbr_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] dx, dy, dz;
    logic [15:0] ry, rx, rz;
  } particle_t;

  typedef struct packed {
    logic [15:0] ox, oy, oz;
    logic [2:0]  mask;
    logic        degen;
  } bounce_t;

  typedef struct packed {
    particle_t p;
    logic      typed;
    bounce_t   res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [15:0] dir_in_x_i = '0, dir_in_y_i = '0, dir_in_z_i = '0;
  logic [15:0] rand_for_y_i = '0, rand_for_x_i = '0, rand_for_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] dir_out_x_o, dir_out_y_o, dir_out_z_o;
  logic [2:0] hit_mask_o;
  logic degenerate_o;
  logic cfg_we_i = 1'b0;
  logic [dbr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [dbr_pkg::LIMIT_W-1:0] cfg_data_i = '0;

  longint lim_x, lim_y, lim_z;
  bounce_t pending_dirs[$];
  int errors = 0;
  int unsigned n_sent = 0;

  diffuse_boundary_reflect #(.DIR_FRAC_BITS(DFB), .RAND_BITS(RB)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit take_gap();
    if (n_sent >= 540 && n_sent < 690) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  // ---- bit-accurate model ----
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint scale_tan(longint t, longint unsigned num,
                                       longint unsigned den);
    longint unsigned mag = (t < 0) ? -t : t;
    longint q = (mag * num + den / 2) / den;
    longint one = longint'(1) << DFB;
    q = (t < 0) ? -q : q;
    if (q > one) q = one;
    if (q < -one) q = -one;
    return q;
  endfunction

  function automatic void bounce_axis(inout longint a, inout longint b,
                                      inout longint c, input bit below,
                                      input logic [15:0] rw, inout bit degen);
    longint unsigned full = 64'd1 << (2 * DFB);
    longint unsigned r = rw & ((64'd1 << RB) - 1);
    longint unsigned aa = (a < 0) ? -a : a;
    longint unsigned sq = aa * aa;
    longint unsigned s_old = (sq < full) ? int_sqrt(full - sq) : 0;
    longint unsigned rq, cosn, sinn;
    if (2 * DFB >= RB) rq = r << (2 * DFB - RB);
    else rq = r >> (RB - 2 * DFB);
    if (rq > full) rq = full;
    cosn = int_sqrt(rq);
    sinn = int_sqrt(full - rq);
    if (s_old == 0) begin
      b = 0;
      c = 0;
      degen = 1'b1;
    end else begin
      b = scale_tan(b, sinn, s_old);
      c = scale_tan(c, sinn, s_old);
    end
    a = below ? longint'(cosn) : -longint'(cosn);
  endfunction

  function automatic bounce_t predict_bounce(particle_t p);
    longint px = longint'($signed(p.px));
    longint py = longint'($signed(p.py));
    longint pz = longint'($signed(p.pz));
    longint dx = longint'($signed(p.dx));
    longint dy = longint'($signed(p.dy));
    longint dz = longint'($signed(p.dz));
    bit degen = 1'b0;
    bounce_t res;
    res.mask = '0;
    if (py < 0 || py > lim_y) begin
      bounce_axis(dy, dx, dz, py < 0, p.ry, degen);
      res.mask[1] = 1'b1;
    end
    if (px < 0 || px > lim_x) begin
      bounce_axis(dx, dy, dz, px < 0, p.rx, degen);
      res.mask[0] = 1'b1;
    end
    if (pz < 0 || pz > lim_z) begin
      bounce_axis(dz, dx, dy, pz < 0, p.rz, degen);
      res.mask[2] = 1'b1;
    end
    res.ox = dx[15:0];
    res.oy = dy[15:0];
    res.oz = dz[15:0];
    res.degen = degen;
    return res;
  endfunction

  // ---- drivers ----
  task automatic send_item(particle_t p, logic typed, bounce_t res);
    if (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (take_gap()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {pos_x_i, pos_y_i, pos_z_i} <= {p.px, p.py, p.pz};
    {dir_in_x_i, dir_in_y_i, dir_in_z_i} <= {p.dx, p.dy, p.dz};
    {rand_for_y_i, rand_for_x_i, rand_for_z_i} <= {p.ry, p.rx, p.rz};
    do @(posedge clk_i); while (!in_ready_o);
    pending_dirs.push_back(typed ? res : predict_bounce(p));
    n_sent++;
  endtask

  task automatic write_limits(logic [dbr_pkg::LIMIT_W-1:0] lx,
                              logic [dbr_pkg::LIMIT_W-1:0] ly,
                              logic [dbr_pkg::LIMIT_W-1:0] lz);
    logic [dbr_pkg::CFG_IDX_W-1:0] idx[4] = '{dbr_pkg::REG_BOX_LIMIT_X,
                                              dbr_pkg::REG_BOX_LIMIT_Y,
                                              dbr_pkg::REG_BOX_LIMIT_Z,
                                              REG_UNUSED};
    logic [dbr_pkg::LIMIT_W-1:0] val[4];
    val = '{lx, ly, lz, dbr_pkg::LIMIT_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        dbr_pkg::REG_BOX_LIMIT_X: lim_x = val[i];
        dbr_pkg::REG_BOX_LIMIT_Y: lim_y = val[i];
        dbr_pkg::REG_BOX_LIMIT_Z: lim_z = val[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_dirs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_pos(longint lim);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'(lim));
      5: return {1'b1, 31'($urandom)};
      6: return (lim < 64'h7fffffff) ? $urandom_range(32'(lim) + 1, 32'h7fffffff)
                                      : 32'($urandom_range(0, 32'(lim)));
      7: case ($urandom_range(0, 5))
           0: return 32'd0;
           1: return 32'(lim);
           2: return 32'hffffffff;
           3: return (lim < 64'h7fffffff) ? 32'(lim + 1) : 32'h7fffffff;
           4: return 32'h80000000;
           default: return 32'h7fffffff;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic dir_row_t row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                   logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                   logic [15:0] ry, logic [15:0] rx, logic [15:0] rz,
                                   logic typed, bounce_t res);
    dir_row_t d;
    d.p = '{px, py, pz, dx, dy, dz, ry, rx, rz};
    d.typed = typed;
    d.res = res;
    return d;
  endfunction

  // ---- result side ----
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_sent >= 200) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ready_i <= !take_gap();
    end
  end

  task automatic chk(string fld, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h %h",
                 $time, dir_out_x_o, dir_out_y_o, dir_out_z_o);
        errors++;
      end else begin
        bounce_t e;
        e = pending_dirs.pop_front();
        chk("dir_out_x", e.ox, dir_out_x_o);
        chk("dir_out_y", e.oy, dir_out_y_o);
        chk("dir_out_z", e.oz, dir_out_z_o);
        chk("hit_mask", 16'(e.mask), 16'(hit_mask_o));
        chk("degenerate", 16'(e.degen), 16'(degenerate_o));
      end
    end
  end

  // ---- main sequence ----
  initial begin
    dir_row_t table_rows[$];
    logic [dbr_pkg::LIMIT_W-1:0] phase_lim[4][3];
    particle_t p;
    lim_x = dbr_pkg::BOX_LIMIT_RST;
    lim_y = dbr_pkg::BOX_LIMIT_RST;
    lim_z = dbr_pkg::BOX_LIMIT_RST;
    phase_lim = '{'{31'd0, 31'd0, 31'd0},
                  '{LIMIT_MAX, LIMIT_MAX, LIMIT_MAX},
                  '{31'd1000, 31'd65536, 31'd7},
                  '{dbr_pkg::LIMIT_W'($urandom), dbr_pkg::LIMIT_W'($urandom),
                    dbr_pkg::LIMIT_W'($urandom)}};

    // pass-through and degenerate rows carry their result
    table_rows.push_back(row(32'd5, 32'd5, 32'd5, 16'sd16384, 16'd0, 16'd0,
                             16'd0, 16'd0, 16'd0, 1'b1,
                             '{16'sd16384, 16'd0, 16'd0, 3'b000, 1'b0}));
    table_rows.push_back(row(32'd0, 32'd1048576, 32'd0, -16'sd16384, 16'd0,
                             16'h7fff, 16'hffff, 16'hffff, 16'hffff, 1'b1,
                             '{-16'sd16384, 16'd0, 16'h7fff, 3'b000, 1'b0}));
    table_rows.push_back(row(32'd1, 32'hffffffff, 32'd1, 16'd1234, 16'sd16384,
                             -16'sd999, 16'd0, 16'd0, 16'd0, 1'b1,
                             '{16'd0, 16'd0, 16'd0, 3'b010, 1'b1}));
    table_rows.push_back(row(32'd1, 32'h7fffffff, 32'd1, 16'd5000, -16'sd8000,
                             16'd3000, 16'd40000, 16'd0, 16'd0, 1'b0, '0));
    table_rows.push_back(row(32'h80000000, 32'd1, 32'd1, -16'sd11585, 16'd11585,
                             16'd0, 16'd0, 16'd12345, 16'd0, 1'b0, '0));
    table_rows.push_back(row(32'd1, 32'd1, 32'd1048577, 16'd0, 16'd9459,
                             -16'sd13377, 16'd0, 16'd0, 16'd65535, 1'b0, '0));
    table_rows.push_back(row(32'hffffffff, 32'h80000000, 32'h7fffffff, 16'd9459,
                             16'd9459, 16'd9459, 16'hffff, 16'hffff, 16'hffff,
                             1'b0, '0));
    table_rows.push_back(row(32'd1, 32'hfffffff0, 32'd1, 16'sd16384, 16'd16000,
                             -16'sd16384, 16'd0, 16'd0, 16'd0, 1'b0, '0));
    table_rows.push_back(row(32'd1048577, 32'd1, 32'd1, -16'sd16384, 16'd0,
                             16'd0, 16'd0, 16'hffff, 16'd0, 1'b0, '0));
    table_rows.push_back(row(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'd1,
                             -16'sd1, 16'd16383, 16'd1, 16'd32768, 16'd2,
                             1'b0, '0));
    table_rows.push_back(row(32'd1048577, 32'd1048577, 32'd1048577, 16'd0,
                             16'd0, 16'd0, 16'd100, 16'd200, 16'd300, 1'b0, '0));
    table_rows.push_back(row(32'h80000000, 32'd7, 32'hfff00000, 16'd16383,
                             16'h8000 + 16'd16384, 16'd1, 16'h5555, 16'haaaa,
                             16'h8000, 1'b0, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send_item(table_rows[i].p, table_rows[i].typed,
                                      table_rows[i].res);

    for (int ph = 0; ph <= 4; ph++) begin
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        drain();
        write_limits(phase_lim[ph-1][0], phase_lim[ph-1][1], phase_lim[ph-1][2]);
      end
      repeat (N_RAND_PER_PHASE) begin
        p.px = pick_pos(lim_x);
        p.py = pick_pos(lim_y);
        p.pz = pick_pos(lim_z);
        p.dx = pick_dir();
        p.dy = pick_dir();
        p.dz = pick_dir();
        p.ry = 16'($urandom);
        p.rx = 16'($urandom);
        p.rz = 16'($urandom);
        send_item(p, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
